>>> rtl/pedal_percent_and_brake_hysteresis_core_macros.svh
`ifndef PEDAL_PERCENT_AND_BRAKE_HYSTERESIS_CORE_MACROS_SVH
`define PEDAL_PERCENT_AND_BRAKE_HYSTERESIS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPBH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppbh check failed");

// next-cycle implication, checked outside reset
`define PPBH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppbh check failed");

`endif

>>> rtl/ppbh_pkg.sv
`default_nettype none

package ppbh_pkg;

	// sample and result beats
	typedef struct packed {
		logic [11:0] throttle_raw;
		logic [11:0] brake_raw;
	} sample_t;

	typedef struct packed {
		logic [6:0] throttle_pct;
		logic [6:0] brake_pct;
		logic       light_on;
		logic       light_changed;
		logic       torque_cut;
		logic       start_allowed;
		logic [6:0] torque_pct;
	} result_t;

	// register map, word index
	typedef enum logic [2:0] {
		REG_THROTTLE_MIN  = 3'd0,
		REG_THROTTLE_MAX  = 3'd1,
		REG_BRAKE_MIN     = 3'd2,
		REG_BRAKE_MAX     = 3'd3,
		REG_LIGHT_ON_PCT  = 3'd4,
		REG_LIGHT_OFF_PCT = 3'd5,
		REG_CUT_HIGH_PCT  = 3'd6,
		REG_CUT_LOW_PCT   = 3'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_FINISH
	} state_t;

	// register reset values
	localparam logic [11:0] THROTTLE_MIN_RST  = 12'd769;
	localparam logic [11:0] THROTTLE_MAX_RST  = 12'd825;
	localparam logic [11:0] BRAKE_MIN_RST     = 12'd20;
	localparam logic [11:0] BRAKE_MAX_RST     = 12'd48;
	localparam logic [6:0]  LIGHT_ON_PCT_RST  = 7'd10;
	localparam logic [6:0]  LIGHT_OFF_PCT_RST = 7'd5;
	localparam logic [6:0]  CUT_HIGH_PCT_RST  = 7'd25;
	localparam logic [6:0]  CUT_LOW_PCT_RST   = 7'd5;

	// brake percent that must be exceeded to allow a start
	localparam logic [6:0]  START_BRAKE_PCT   = 7'd10;
	localparam logic [6:0]  FULL_SCALE_PCT    = 7'd100;

	// top quotient bit of the divide, quotient never exceeds 100
	localparam logic [2:0]  DIV_TOP_BIT       = 3'd6;

endpackage

`default_nettype wire

>>> rtl/pedal_percent_and_brake_hysteresis_core.sv
// Pedal percent and brake hysteresis core. Each sample beat carries a raw throttle and a raw
// brake reading; each is clamped to its calibrated min..max window and scaled to a whole
// percent (x - min) * 100 / (max - min), truncated, with 0 for a window where max <= min.
// The brake percent drives two hysteresis flags (brake light, torque cut), a start
// permission flag (brake percent above 10) and a torque demand that is 0 while cut and the
// throttle percent otherwise. One result beat per sample. A single restoring divider is
// shared by both channels: per channel a setup step, then compare-subtract steps from
// quotient bit 6 down to bit 0; a finish step then settles the flags and loads the output
// register, waiting while an earlier result is unclaimed. sample_ready is high only while
// the sequencer is idle; a finished result waits in an output register, so a new sample
// can be taken while the previous result is still unclaimed. Calibration registers sit on
// an APB-style port at byte addresses 0x00..0x1C and must only be written while the core is idle.
`default_nettype none

`include "pedal_percent_and_brake_hysteresis_core_macros.svh"

module pedal_percent_and_brake_hysteresis_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	input  wire ppbh_pkg::sample_t sample,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output ppbh_pkg::result_t     result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [4:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ppbh_pkg::*;

	// calibration registers
	logic [11:0] throttle_min_q, throttle_max_q, brake_min_q, brake_max_q;
	logic [6:0]  light_on_pct_q, light_off_pct_q, cut_high_pct_q, cut_low_pct_q;

	// sequencer and datapath registers
	state_t      state_q, state_d;
	logic        ch_q;
	logic [11:0] t_raw_q, b_raw_q;
	logic [18:0] rem_q;
	logic [11:0] den_q;
	logic [6:0]  quo_q;
	logic [2:0]  bit_q;
	logic [6:0]  t_pct_q, b_pct_q;
	logic        light_q, cut_q;
	logic        result_valid_q;
	result_t     result_q;

	// sequencer strobes
	logic        take_sample, load_setup, div_step, finish_load;

	logic        cfg_write;
	reg_idx_t    cfg_idx;

	assign pready    = 1'b1;
	assign cfg_idx   = reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_min_q  <= THROTTLE_MIN_RST;
			throttle_max_q  <= THROTTLE_MAX_RST;
			brake_min_q     <= BRAKE_MIN_RST;
			brake_max_q     <= BRAKE_MAX_RST;
			light_on_pct_q  <= LIGHT_ON_PCT_RST;
			light_off_pct_q <= LIGHT_OFF_PCT_RST;
			cut_high_pct_q  <= CUT_HIGH_PCT_RST;
			cut_low_pct_q   <= CUT_LOW_PCT_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_THROTTLE_MIN:  throttle_min_q  <= pwdata[11:0];
				REG_THROTTLE_MAX:  throttle_max_q  <= pwdata[11:0];
				REG_BRAKE_MIN:     brake_min_q     <= pwdata[11:0];
				REG_BRAKE_MAX:     brake_max_q     <= pwdata[11:0];
				REG_LIGHT_ON_PCT:  light_on_pct_q  <= pwdata[6:0];
				REG_LIGHT_OFF_PCT: light_off_pct_q <= pwdata[6:0];
				REG_CUT_HIGH_PCT:  cut_high_pct_q  <= pwdata[6:0];
				REG_CUT_LOW_PCT:   cut_low_pct_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_THROTTLE_MIN:  prdata = {20'd0, throttle_min_q};
			REG_THROTTLE_MAX:  prdata = {20'd0, throttle_max_q};
			REG_BRAKE_MIN:     prdata = {20'd0, brake_min_q};
			REG_BRAKE_MAX:     prdata = {20'd0, brake_max_q};
			REG_LIGHT_ON_PCT:  prdata = {25'd0, light_on_pct_q};
			REG_LIGHT_OFF_PCT: prdata = {25'd0, light_off_pct_q};
			REG_CUT_HIGH_PCT:  prdata = {25'd0, cut_high_pct_q};
			REG_CUT_LOW_PCT:   prdata = {25'd0, cut_low_pct_q};
			default:           prdata = 32'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (sample_valid) state_d = ST_SETUP;
			ST_SETUP:  state_d = ST_DIV;
			ST_DIV: begin
				if (bit_q == 3'd0) state_d = ch_q ? ST_FINISH : ST_SETUP;
			end
			ST_FINISH: if (!result_valid_q || result_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		load_setup   = 1'b0;
		div_step     = 1'b0;
		finish_load  = 1'b0;
		case (state_q)
			ST_IDLE:   sample_ready = 1'b1;
			ST_SETUP:  load_setup   = 1'b1;
			ST_DIV:    div_step     = 1'b1;
			ST_FINISH: finish_load  = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	assign take_sample = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// channel operands for the setup cycle
	logic [11:0] sel_x, sel_lo, sel_hi, off, span;
	logic        window_ok;
	logic [18:0] off_x100;

	always_comb begin
		sel_x     = ch_q ? b_raw_q     : t_raw_q;
		sel_lo    = ch_q ? brake_min_q : throttle_min_q;
		sel_hi    = ch_q ? brake_max_q : throttle_max_q;
		window_ok = sel_hi > sel_lo;
		span      = sel_hi - sel_lo;
		if (sel_x < sel_lo)      off = 12'd0;
		else if (sel_x > sel_hi) off = span;
		else                     off = sel_x - sel_lo;
		// times 100 as 64 + 32 + 4
		off_x100  = ({7'd0, off} << 6) + ({7'd0, off} << 5) + ({7'd0, off} << 2);
	end

	// shared compare-subtract step
	logic [19:0] trial;
	logic [6:0]  quo_d;

	always_comb begin
		trial = {1'b0, rem_q} - ({8'd0, den_q} << bit_q);
		quo_d = quo_q;
		if (!trial[19]) quo_d[bit_q] = 1'b1;
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (take_sample) begin
			t_raw_q <= sample.throttle_raw;
			b_raw_q <= sample.brake_raw;
		end
		if (load_setup) begin
			rem_q <= window_ok ? off_x100 : 19'd0;
			den_q <= window_ok ? span : 12'd1;
			quo_q <= 7'd0;
			bit_q <= DIV_TOP_BIT;
		end else if (div_step) begin
			if (!trial[19]) rem_q <= trial[18:0];
			quo_q <= quo_d;
			bit_q <= bit_q - 3'd1;
			if (bit_q == 3'd0) begin
				if (ch_q) b_pct_q <= quo_d;
				else      t_pct_q <= quo_d;
			end
		end
	end

	// channel select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= 1'b0;
		end else if (take_sample) begin
			ch_q <= 1'b0;
		end else if (div_step && bit_q == 3'd0) begin
			ch_q <= 1'b1;
		end
	end

	// hysteresis update
	logic light_rise, light_fall, light_d, cut_d;

	always_comb begin
		light_rise = (b_pct_q >= light_on_pct_q) && !light_q;
		light_fall = (b_pct_q < light_off_pct_q) && light_q;
		light_d    = light_rise ? 1'b1 : (light_fall ? 1'b0 : light_q);
		cut_d      = cut_q;
		if (b_pct_q > cut_high_pct_q) cut_d = 1'b1;
		if (b_pct_q < cut_low_pct_q)  cut_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= 1'b0;
			cut_q   <= 1'b0;
		end else if (finish_load) begin
			light_q <= light_d;
			cut_q   <= cut_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          result_valid_q <= 1'b0;
		else if (finish_load) result_valid_q <= 1'b1;
		else if (result_ready) result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish_load) begin
			result_q.throttle_pct  <= t_pct_q;
			result_q.brake_pct     <= b_pct_q;
			result_q.light_on      <= light_d;
			result_q.light_changed <= light_rise || light_fall;
			result_q.torque_cut    <= cut_d;
			result_q.start_allowed <= b_pct_q > START_BRAKE_PCT;
			result_q.torque_pct    <= cut_d ? 7'd0 : t_pct_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`PPBH_ASSERT_NOW(a_cut_zero_torque, result_valid && result.torque_cut, result.torque_pct == 7'd0)
	`PPBH_ASSERT_NOW(a_light_matches, result_valid, result.light_on == light_q)
	`PPBH_ASSERT_NOW(a_throttle_range, result_valid, result.throttle_pct <= FULL_SCALE_PCT)
	`PPBH_ASSERT_NOW(a_brake_range, result_valid, result.brake_pct <= FULL_SCALE_PCT)
	`PPBH_ASSERT_NEXT(a_accept_starts, sample_valid && sample_ready, (state_q == ST_SETUP) && !ch_q)

endmodule

`default_nettype wire
